>>> design/assert_macros.svh
// Assertion macros used by the RTL module of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
// Condition that must never hold at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> design/eabfr_pkg.sv
// Package with the constants, word layout and CRC function of the frame receiver.
package eabfr_pkg;

	// Frame byte positions.
	localparam logic [2:0] POS_FIRST  = 3'd0;
	localparam logic [2:0] POS_SECOND = 3'd1;
	localparam logic [2:0] POS_HIGH   = 3'd2;
	localparam logic [2:0] POS_MID    = 3'd3;
	localparam logic [2:0] POS_LOW    = 3'd4;
	localparam logic [2:0] POS_CRC    = 3'd5;
	localparam logic [2:0] POS_IDLE   = 3'd6;

	// CRC-8 generator polynomial, initial value zero.
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;

	// Result word layout, highest bits first.
	localparam int ANGLE_W = 21;
	localparam int CRC_W   = 8;
	localparam int RES_W   = ANGLE_W + 2 * CRC_W + 1;
	localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

	typedef struct packed {
		logic             crc_match;
		logic [CRC_W-1:0] crc_computed;
		logic [CRC_W-1:0] crc_received;
		logic [ANGLE_W-1:0] angle_raw;
	} result_t;

	// One byte of CRC-8, most significant bit first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> design/encoder_angle_burst_frame_receiver.sv
// Burst angle frame receiver: byte tracking, CRC-8 check and result output.
// The result word is registered in the output register, or in the skid register if a word waits.
// Throughput: one byte per cycle while the skid register is empty.
// An output register plus one skid register keep input flowing while a result waits.
// Reset (arst_n low, asynchronous) empties the output and leaves the block idle
// until a word with frame_start arrives.
`include "assert_macros.svh"

module encoder_angle_burst_frame_receiver
	import eabfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] rx_byte
	input  logic             s_axis_tuser,  // [0] frame_start
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // [20:0] angle_raw, [28:21] crc_received,
	                                        // [36:29] crc_computed, [37] crc_match, rest zero
);

	logic [2:0] pos_q;
	logic [7:0] crc_q;
	logic [7:0] high_q;
	logic [7:0] mid_q;
	logic [7:0] low_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	result_t    out_q;
	result_t    skid_q;

	logic       accept;
	logic [2:0] pos_eff;
	logic [7:0] crc_eff;
	logic [7:0] crc_upd;
	logic [2:0] pos_next;
	logic       res_fire;
	result_t    res;

	// A word is taken whenever the skid register is free.
	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// A frame start restarts at byte zero with a cleared CRC.
	assign pos_eff = s_axis_tuser ? POS_FIRST : pos_q;
	assign crc_eff = s_axis_tuser ? CRC_INIT : crc_q;
	assign crc_upd = crc8_update(crc_eff, s_axis_tdata);

	// Next byte position; saturates at idle after the CRC byte.
	always_comb begin
		case (pos_eff)
			POS_FIRST:  pos_next = POS_SECOND;
			POS_SECOND: pos_next = POS_HIGH;
			POS_HIGH:   pos_next = POS_MID;
			POS_MID:    pos_next = POS_LOW;
			POS_LOW:    pos_next = POS_CRC;
			default:    pos_next = POS_IDLE;
		endcase
	end

	// Result assembled from the captured payload and the CRC byte.
	assign res_fire         = accept && (pos_eff == POS_CRC);
	assign res.angle_raw    = {high_q, mid_q, low_q[7:3]};
	assign res.crc_received = s_axis_tdata;
	assign res.crc_computed = crc_eff;
	assign res.crc_match    = (crc_eff == s_axis_tdata);

	// Byte position and CRC accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			crc_q <= CRC_INIT;
		end else if (accept) begin
			pos_q <= pos_next;
			if (pos_eff == POS_HIGH || pos_eff == POS_MID || pos_eff == POS_LOW) begin
				crc_q <= crc_upd;
			end else begin
				crc_q <= crc_eff;
			end
		end
	end

	// Payload byte capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (pos_eff)
				POS_HIGH: high_q <= s_axis_tdata;
				POS_MID:  mid_q  <= s_axis_tdata;
				POS_LOW:  low_q  <= s_axis_tdata;
				default:  ;
			endcase
		end
	end

	// Output and skid valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q  <= skid_valid_q || res_fire;
			skid_valid_q <= 1'b0;
		end else if (res_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output and skid data.
	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_fire) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, out_q};

	// The skid register only fills behind a waiting output word.
	`ASSERT_CLK(a_skid_behind_out, skid_valid_q |-> out_valid_q)
	// An accepted CRC byte is always followed by a valid output word on the next cycle.
	`ASSERT_CLK(a_crc_byte_result, res_fire |=> out_valid_q)
	// The byte position never reaches the unused code.
	`ASSERT_NEVER(a_pos_legal, pos_q == 3'd7)
	// The match flag agrees with the two CRC fields of the output word.
	`ASSERT_CLK(a_match_flag, out_valid_q |->
		(out_q.crc_match == (out_q.crc_computed == out_q.crc_received)))

endmodule

>>> sim/tb.sv
// Testbench for the burst angle frame receiver: byte stream stimulus, CRC-8 prediction and result checks.
`timescale 1ns / 1ps

module tb;
	import eabfr_pkg::*;

	// One byte as it travels on the input stream.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_word_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;   // [7:0] rx_byte
	logic             s_axis_tuser = 1'b0; // [0] frame_start
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // [20:0] angle_raw, [28:21] crc_received,
	                                       // [36:29] crc_computed, [37] crc_match

	encoder_angle_burst_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	rx_word_t   rx_words_pending[$];
	result_t    angle_words_due[$];
	rx_word_t   next_rx_word;
	result_t    seen_word;
	result_t    due_word;
	int         send_gap = 0;
	int         recv_stall = 0;
	int         calm_left = 0;
	logic       calm = 1'b0;
	int         error_count = 0;
	int         frames_seen = 0;
	int         crc_good_seen = 0;
	int         frames_queued = 0;

	// Shadow of the receiver state.
	logic [2:0] frame_pos = POS_IDLE;
	logic [7:0] crc_acc = CRC_INIT;
	logic [7:0] ang_hi = '0;
	logic [7:0] ang_mid = '0;
	logic [7:0] ang_lo = '0;

	always #6 clk = ~clk;

	// CRC-8, polynomial 0x07, one byte shifted in most significant bit first.
	function automatic logic [7:0] crc8_poly07(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// Idle length for either side: none in calm stretches, else mostly none or short, sometimes long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm) begin
			return 0;
		end
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 25);
	endfunction

	task automatic push_word(input logic [7:0] b, input logic start);
		rx_word_t w;
		w.rx_byte = b;
		w.frame_start = start;
		rx_words_pending.push_back(w);
	endtask

	// A whole burst frame: two filler bytes, three payload bytes and the CRC byte.
	task automatic push_frame(input logic [7:0] hi, input logic [7:0] mid,
	                          input logic [7:0] lo, input logic crc_good);
		logic [7:0] c;
		logic [7:0] sent;
		c = crc8_poly07(crc8_poly07(crc8_poly07(CRC_INIT, hi), mid), lo);
		sent = c;
		if (!crc_good) begin
			sent = c ^ 8'($urandom_range(1, 255));
		end
		push_word(8'($urandom), 1'b1);
		push_word(8'($urandom), 1'b0);
		push_word(hi, 1'b0);
		push_word(mid, 1'b0);
		push_word(lo, 1'b0);
		push_word(sent, 1'b0);
		frames_queued++;
	endtask

	// Alternate calm stretches, with no idling on either side, and busy ones.
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm <= ~calm;
			calm_left <= $urandom_range(40, 250);
		end else begin
			calm_left <= calm_left - 1;
		end
	end

	// Input driver: next word once the current one is taken, after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0 || rx_words_pending.size() == 0) begin
				s_axis_tvalid <= 1'b0;
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end
			end else begin
				next_rx_word = rx_words_pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_rx_word.rx_byte;
				s_axis_tuser <= next_rx_word.frame_start;
				send_gap <= idle_len();
			end
		end
	end

	// Output side back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else if (recv_stall > 0) begin
			m_axis_tready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else begin
			m_axis_tready <= 1'b1;
			recv_stall <= idle_len();
		end
	end

	// Predict on every accepted input word, check every accepted result word.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (s_axis_tuser) begin
				frame_pos = POS_FIRST;
				crc_acc = CRC_INIT;
			end
			case (frame_pos)
				POS_FIRST, POS_SECOND: begin
					frame_pos = frame_pos + 3'd1;
				end
				POS_HIGH: begin
					ang_hi = s_axis_tdata;
					crc_acc = crc8_poly07(crc_acc, s_axis_tdata);
					frame_pos = POS_MID;
				end
				POS_MID: begin
					ang_mid = s_axis_tdata;
					crc_acc = crc8_poly07(crc_acc, s_axis_tdata);
					frame_pos = POS_LOW;
				end
				POS_LOW: begin
					ang_lo = s_axis_tdata;
					crc_acc = crc8_poly07(crc_acc, s_axis_tdata);
					frame_pos = POS_CRC;
				end
				POS_CRC: begin
					due_word.angle_raw = {ang_hi, ang_mid, ang_lo[7:3]};
					due_word.crc_received = s_axis_tdata;
					due_word.crc_computed = crc_acc;
					due_word.crc_match = (crc_acc == s_axis_tdata);
					angle_words_due.push_back(due_word);
					frame_pos = POS_IDLE;
				end
				default: begin
					frame_pos = POS_IDLE;
				end
			endcase
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_word = m_axis_tdata[RES_W-1:0];
			if (angle_words_due.size() == 0) begin
				$error("unexpected result word %0h", seen_word);
				error_count++;
			end else begin
				due_word = angle_words_due.pop_front();
				frames_seen++;
				if (seen_word.crc_match) begin
					crc_good_seen++;
				end
				if (seen_word.angle_raw !== due_word.angle_raw) begin
					$error("angle_raw expected %0h got %0h",
					       due_word.angle_raw, seen_word.angle_raw);
					error_count++;
				end
				if (seen_word.crc_received !== due_word.crc_received) begin
					$error("crc_received expected %0h got %0h",
					       due_word.crc_received, seen_word.crc_received);
					error_count++;
				end
				if (seen_word.crc_computed !== due_word.crc_computed) begin
					$error("crc_computed expected %0h got %0h",
					       due_word.crc_computed, seen_word.crc_computed);
					error_count++;
				end
				if (seen_word.crc_match !== due_word.crc_match) begin
					$error("crc_match expected %0h got %0h",
					       due_word.crc_match, seen_word.crc_match);
					error_count++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int words_counted;
		int r;
		int n;

		// Directed part. A byte before any frame start is ignored.
		push_word(8'hFF, 1'b0);
		push_frame(8'hFF, 8'hFF, 8'hFF, 1'b1);
		// A byte after the CRC byte is ignored.
		push_word(8'h5A, 1'b0);
		push_frame(8'h00, 8'h00, 8'h00, 1'b0);
		// A frame cut short by a new frame start produces nothing.
		push_word(8'h00, 1'b1);
		push_word(8'hFF, 1'b0);
		push_word(8'h12, 1'b0);
		push_word(8'h34, 1'b0);
		push_frame(8'hA5, 8'h5A, 8'hC3, 1'b1);

		// Random part: mostly well-formed frames, some broken ones and noise.
		words_counted = 0;
		while (words_counted < 930) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				push_frame(8'($urandom), 8'($urandom), 8'($urandom),
				           $urandom_range(0, 9) < 7);
				words_counted += 6;
			end else if (r < 88) begin
				n = $urandom_range(1, 5);
				push_word(8'($urandom), 1'b1);
				for (int i = 1; i < n; i++) begin
					push_word(8'($urandom), 1'b0);
				end
				words_counted += n;
			end else if (r < 95) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					push_word(8'($urandom), 1'b0);
				end
			end else begin
				push_frame(8'($urandom_range(0, 1) ? 8'hFF : 8'h00),
				           8'($urandom), 8'($urandom_range(0, 1) ? 8'hFF : 8'h00), 1'b1);
				words_counted += 6;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all words sent, all results back, then a short settle.
		while (rx_words_pending.size() != 0 || s_axis_tvalid) begin
			@(posedge clk);
		end
		while (angle_words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Sent %0d burst frames among noise and cut-short frames.", frames_queued);
		$display("Checked %0d result words, %0d with a matching CRC.",
		         frames_seen, crc_good_seen);
		if (error_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#10_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/eabfr_pkg.sv
design/encoder_angle_burst_frame_receiver.sv
sim/tb.sv
